### hdl/gcd_pkg.sv
// Shared types, constants and the arctangent table for the great circle distance pipeline.
`default_nettype none
package gcd_pkg;

  localparam int CORDIC_STAGES = 24;
  localparam int CW            = 34;
  localparam int SQRT_STAGES   = 31;

  typedef logic signed [CW-1:0] cw_t;
  typedef logic signed [31:0]   q30_t;
  typedef logic signed [63:0]   p64_t;

  localparam logic signed [26:0] DEG_FULL    = 27'sd23592960;
  localparam logic signed [26:0] DEG_HALF    = 27'sd11796480;
  localparam logic signed [26:0] DEG_QUARTER = 27'sd5898240;
  localparam logic signed [25:0] RAD_PER_DEG = 26'sd18740330;
  localparam cw_t                GAIN        = 34'sd652032874;
  localparam cw_t                HALF_PI     = 34'sd1686629713;
  localparam q30_t               ONE_Q30     = 32'sd1073741824;
  localparam p64_t               RND30       = 64'sd536870912;
  localparam logic [23:0]        RADIUS_RST  = 24'd6378000;

  // truncated atan(2^-i) in Q30
  function automatic cw_t atan_entry(input int i);
    cw_t v;
    case (i)
      0: v = 34'sd843314856;
      1: v = 34'sd497837829;
      2: v = 34'sd263043836;
      3: v = 34'sd133525158;
      4: v = 34'sd67021686;
      5: v = 34'sd33543515;
      6: v = 34'sd16775850;
      7: v = 34'sd8388437;
      8: v = 34'sd4194282;
      9: v = 34'sd2097149;
      default: begin
        if (i < 30) v = cw_t'((64'sd1 <<< (30 - i)) - 64'sd1);
        else v = '0;
      end
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### hdl/gcd_sincos.sv
// Angle reduction and pipelined rotation CORDIC giving sine and cosine in Q30.
`default_nettype none
module gcd_sincos import gcd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic signed [24:0] angle,
  output logic                    out_valid,
  output q30_t                    sin_out,
  output q30_t                    cos_out
);

  logic signed [26:0] d0, d1, d2, d3, d4;
  logic signed [26:0] red_nxt;
  logic               flip_nxt;
  logic signed [23:0] red_r;
  logic               fa_r, va_r;
  logic signed [49:0] prod;

  cw_t  x_r [0:CORDIC_STAGES];
  cw_t  y_r [0:CORDIC_STAGES];
  cw_t  z_r [0:CORDIC_STAGES];
  logic f_r [0:CORDIC_STAGES];
  logic v_r [0:CORDIC_STAGES];

  // bring the angle to [-180,180) degrees, then fold into [-90,90]
  always_comb begin
    d0 = {{2{angle[24]}}, angle};
    d1 = (d0 >= DEG_HALF) ? d0 - DEG_FULL : d0;
    d2 = (d1 >= DEG_HALF) ? d1 - DEG_FULL : d1;
    d3 = (d2 < -DEG_HALF) ? d2 + DEG_FULL : d2;
    d4 = (d3 < -DEG_HALF) ? d3 + DEG_FULL : d3;
    flip_nxt = 1'b0;
    red_nxt  = d4;
    if (d4 > DEG_QUARTER) begin
      red_nxt  = d4 - DEG_HALF;
      flip_nxt = 1'b1;
    end else if (d4 < -DEG_QUARTER) begin
      red_nxt  = d4 + DEG_HALF;
      flip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r  <= in_valid;
      red_r <= red_nxt[23:0];
      fa_r  <= flip_nxt;
    end
  end

  assign prod = red_r * RAD_PER_DEG;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= va_r;
      x_r[0] <= GAIN;
      y_r[0] <= '0;
      z_r[0] <= cw_t'((prod + 50'sd32768) >>> 16);
      f_r[0] <= fa_r;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
        f_r[i+1] <= f_r[i];
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_entry(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_entry(i);
        end
      end
    end
  end

  // undo the half-turn fold
  assign out_valid = v_r[CORDIC_STAGES];
  assign sin_out = q30_t'(f_r[CORDIC_STAGES] ? -y_r[CORDIC_STAGES] : y_r[CORDIC_STAGES]);
  assign cos_out = q30_t'(f_r[CORDIC_STAGES] ? -x_r[CORDIC_STAGES] : x_r[CORDIC_STAGES]);

endmodule
`default_nettype wire

### hdl/gcd_term.sv
// Pipelined law-of-cosines term, clamp to [-1,1] and its square.
`default_nettype none
module gcd_term import gcd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire logic in_valid,
  input  wire q30_t sa,
  input  wire q30_t ca,
  input  wire q30_t sb,
  input  wire q30_t cb,
  input  wire q30_t sla,
  input  wire q30_t cla,
  input  wire q30_t slb,
  input  wire q30_t clb,
  output logic        out_valid,
  output q30_t        t_out,
  output logic [61:0] tt_out
);

  p64_t pa_r, pb_r, pc_r, ps1_r;
  q30_t lon_r, mcc_r;
  p64_t ps2_r, ps3_r, q_r;
  p64_t tsum;
  q30_t t_nxt, t4_r, t5_r;
  p64_t sq;
  logic [61:0] tt_r;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  always_comb begin
    tsum = (ps3_r + q_r + RND30) >>> 30;
    if (tsum > p64_t'(ONE_Q30)) t_nxt = ONE_Q30;
    else if (tsum < -p64_t'(ONE_Q30)) t_nxt = -ONE_Q30;
    else t_nxt = q30_t'(tsum);
  end

  assign sq = t4_r * t4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r  <= in_valid;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
      v5_r  <= v4_r;
      pa_r  <= p64_t'(cla) * p64_t'(clb);
      pb_r  <= p64_t'(sla) * p64_t'(slb);
      pc_r  <= p64_t'(ca) * p64_t'(cb);
      ps1_r <= p64_t'(sa) * p64_t'(sb);
      lon_r <= q30_t'((pa_r + pb_r + RND30) >>> 30);
      mcc_r <= q30_t'((pc_r + RND30) >>> 30);
      ps2_r <= ps1_r;
      q_r   <= p64_t'(mcc_r) * p64_t'(lon_r);
      ps3_r <= ps2_r;
      t4_r  <= t_nxt;
      tt_r  <= sq[61:0];
      t5_r  <= t4_r;
    end
  end

  assign out_valid = v5_r;
  assign t_out     = t5_r;
  assign tt_out    = tt_r;

endmodule
`default_nettype wire

### hdl/gcd_acos.sv
// Pipelined square root and vectoring CORDIC giving the arc cosine in Q30 radians.
`default_nettype none
module gcd_acos import gcd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire q30_t        t_in,
  input  wire logic [61:0] tt_in,
  output logic             out_valid,
  output logic [31:0]      angle
);

  logic [61:0] n_r  [0:SQRT_STAGES];
  logic [61:0] r_r  [0:SQRT_STAGES];
  q30_t        tp_r [0:SQRT_STAGES];
  logic        sv_r [0:SQRT_STAGES];

  cw_t  x_r [0:CORDIC_STAGES];
  cw_t  y_r [0:CORDIC_STAGES];
  cw_t  z_r [0:CORDIC_STAGES];
  logic v_r [0:CORDIC_STAGES];

  cw_t s_ext, t_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r[0] <= 1'b0;
    end else if (en) begin
      sv_r[0] <= in_valid;
      n_r[0]  <= (62'd1 << 60) - tt_in;
      r_r[0]  <= '0;
      tp_r[0] <= t_in;
    end
  end

  // one result bit per stage
  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    localparam logic [61:0] BIT = 62'd1 << (60 - 2 * k);
    logic [61:0] trial;
    assign trial = r_r[k] + BIT;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k+1] <= 1'b0;
      end else if (en) begin
        sv_r[k+1] <= sv_r[k];
        tp_r[k+1] <= tp_r[k];
        if (n_r[k] >= trial) begin
          n_r[k+1] <= n_r[k] - trial;
          r_r[k+1] <= (r_r[k] >> 1) + BIT;
        end else begin
          n_r[k+1] <= n_r[k];
          r_r[k+1] <= r_r[k] >> 1;
        end
      end
    end
  end

  assign s_ext = cw_t'(r_r[SQRT_STAGES][32:0]);
  assign t_ext = cw_t'(tp_r[SQRT_STAGES]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= sv_r[SQRT_STAGES];
      if (t_ext < 0) begin
        x_r[0] <= s_ext;
        y_r[0] <= -t_ext;
        z_r[0] <= HALF_PI;
      end else begin
        x_r[0] <= t_ext;
        y_r[0] <= s_ext;
        z_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
        if (y_r[i] > 0) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_entry(i);
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_entry(i);
        end
      end
    end
  end

  // drop negative angles to zero
  assign out_valid = v_r[CORDIC_STAGES];
  assign angle = z_r[CORDIC_STAGES][CW-1] ? 32'd0 : z_r[CORDIC_STAGES][31:0];

endmodule
`default_nettype wire

### hdl/great_circle_distance.sv
// Great circle distance between two points, fully pipelined.
//
// Input channel in_*: one transaction carries both points, latitudes and
// longitudes in signed degrees with 16 fraction bits. Output channel out_*:
// one transaction per input, the distance in meters with 8 fraction bits,
// saturated at the 34-bit maximum. Configuration channel cfg_*: writes the
// sphere radius in whole meters; cfg_ready is always high.
//
// Throughput: one transaction per cycle while the output is not stalled.
// The two CORDIC chains on the path run one stage per iteration, and the
// 31-stage square root gives one result bit per stage.
//
// Reset clears all valid bits and loads the radius with 6378000 m.
// When the receiver holds out_tready low with a result waiting, the whole
// pipeline freezes and in_tready drops with it; nothing is lost or repeated.
`default_nettype none
module great_circle_distance import gcd_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // first_latitude[23:0], first_longitude[48:24], second_latitude[72:49],
  // second_longitude[97:73], zero pad [103:98]
  input  wire logic [103:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // arc_distance[33:0], zero pad [39:34]
  output logic [39:0]       out_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [23:0]  cfg_data
);

  logic        en;
  logic [23:0] radius_r;
  logic        v0, v1, v2, v3;
  q30_t        sa, ca, sla, cla, sb, cb, slb, clb;
  logic        term_v;
  q30_t        t;
  logic [61:0] tt;
  logic        ang_v;
  logic [31:0] ang;
  logic [55:0] p_r;
  logic        pv_r;
  logic [34:0] d;
  logic [33:0] dist_r;
  logic        out_valid_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
    end else if (cfg_valid) begin
      radius_r <= cfg_data;
    end
  end

  gcd_sincos u_lat_a (
    .clk, .rst_n, .en, .in_valid(in_tvalid),
    .angle({in_tdata[23], in_tdata[23:0]}),
    .out_valid(v0), .sin_out(sa), .cos_out(ca)
  );
  gcd_sincos u_lon_a (
    .clk, .rst_n, .en, .in_valid(in_tvalid),
    .angle(in_tdata[48:24]),
    .out_valid(v1), .sin_out(sla), .cos_out(cla)
  );
  gcd_sincos u_lat_b (
    .clk, .rst_n, .en, .in_valid(in_tvalid),
    .angle({in_tdata[72], in_tdata[72:49]}),
    .out_valid(v2), .sin_out(sb), .cos_out(cb)
  );
  gcd_sincos u_lon_b (
    .clk, .rst_n, .en, .in_valid(in_tvalid),
    .angle(in_tdata[97:73]),
    .out_valid(v3), .sin_out(slb), .cos_out(clb)
  );

  gcd_term u_term (
    .clk, .rst_n, .en, .in_valid(v0 & v1 & v2 & v3),
    .sa, .ca, .sb, .cb, .sla, .cla, .slb, .clb,
    .out_valid(term_v), .t_out(t), .tt_out(tt)
  );

  gcd_acos u_acos (
    .clk, .rst_n, .en, .in_valid(term_v),
    .t_in(t), .tt_in(tt),
    .out_valid(ang_v), .angle(ang)
  );

  assign d = 35'((p_r + 56'd2097152) >> 22);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      pv_r        <= ang_v;
      out_valid_r <= pv_r;
      p_r         <= 56'(radius_r) * 56'(ang);
      dist_r      <= d[34] ? {34{1'b1}} : d[33:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, dist_r};

endmodule
`default_nettype wire

### hdl/gcd_checker.sv
// Port-level checks for the great circle distance block, bound to the top level.
`default_nettype none
module gcd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output transaction changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // input side runs exactly when the output register can move
  a_ready_follow: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:34] == 6'd0)
    else $error("output pad bits not zero");

endmodule

bind great_circle_distance gcd_checker u_gcd_checker (.*);
`default_nettype wire
